### rtl/core/mscd_pkg.sv
// shared types, operation codes and constants of the single-cycle datapath
package mscd_pkg;

  localparam int DEF_DATA_ENTRIES  = 64;
  localparam int DEF_PROGRAM_WORDS = 1024;

  localparam logic [31:0] GP_PRESET = 32'h1000_8000;
  localparam logic [31:0] SP_PRESET = 32'h7FFF_FFFC;
  localparam logic [4:0]  REG_ZERO  = 5'd0;
  localparam logic [4:0]  REG_GP    = 5'd28;
  localparam logic [4:0]  REG_SP    = 5'd29;
  localparam logic [4:0]  REG_RA    = 5'd31;

  // operation codes
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADDU  = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SUBU  = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_OR    = 5'd5;
  localparam logic [4:0] OP_NOR   = 5'd6;
  localparam logic [4:0] OP_SLT   = 5'd7;
  localparam logic [4:0] OP_SLTU  = 5'd8;
  localparam logic [4:0] OP_ADDI  = 5'd9;
  localparam logic [4:0] OP_ADDIU = 5'd10;
  localparam logic [4:0] OP_ANDI  = 5'd11;
  localparam logic [4:0] OP_ORI   = 5'd12;
  localparam logic [4:0] OP_SLTI  = 5'd13;
  localparam logic [4:0] OP_SLTIU = 5'd14;
  localparam logic [4:0] OP_SLL   = 5'd15;
  localparam logic [4:0] OP_SRL   = 5'd16;
  localparam logic [4:0] OP_LW    = 5'd17;
  localparam logic [4:0] OP_SW    = 5'd18;
  localparam logic [4:0] OP_BEQ   = 5'd19;
  localparam logic [4:0] OP_BNE   = 5'd20;
  localparam logic [4:0] OP_J     = 5'd21;
  localparam logic [4:0] OP_JAL   = 5'd22;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_LOOK,
    S_CMP,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic srch_init;
    logic srch_next;
    logic mark_hit;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_mem;
    logic at_end;
    logic hit;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] reg_preset(input logic [4:0] n);
    logic [31:0] v;
    v = '0;
    if (n == REG_GP) v = GP_PRESET;
    if (n == REG_SP) v = SP_PRESET;
    return v;
  endfunction

endpackage

### rtl/core/mscd_ctrl.sv
// sequencer for the datapath: operand read, execute, store search, commit
module mscd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mscd_pkg::sts_t sts,
  output mscd_pkg::cmd_t cmd
);
  import mscd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_READ;
      S_READ:   state_next = S_EXEC;
      S_EXEC:   state_next = sts.is_mem ? S_LOOK : S_COMMIT;
      S_LOOK:   state_next = sts.at_end ? S_COMMIT : S_CMP;
      S_CMP:    state_next = sts.hit ? S_COMMIT : S_LOOK;
      S_COMMIT: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.srch_init = 1'b1;
      end
      S_CMP: begin
        cmd.mark_hit  = sts.hit;
        cmd.srch_next = !sts.hit;
      end
      S_COMMIT: cmd.commit = sts.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/mscd_dp.sv
// datapath: register file, alu, program counter, data store and result register
module mscd_dp #(
  parameter int DATA_ENTRIES  = mscd_pkg::DEF_DATA_ENTRIES,
  parameter int PROGRAM_WORDS = mscd_pkg::DEF_PROGRAM_WORDS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [71:0]    in_word,
  input  mscd_pkg::cmd_t cmd,
  output mscd_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [119:0]   out_word
);
  import mscd_pkg::*;

  localparam int PC_W  = $clog2(PROGRAM_WORDS);
  localparam int IDX_W = $clog2(DATA_ENTRIES);
  localparam int CNT_W = $clog2(DATA_ENTRIES + 1);

  // target reduction modulo the program size by restoring subtraction
  function automatic logic [PC_W-1:0] wrap_tgt(input logic [9:0] t);
    logic [22:0] v;
    v = 23'(t);
    for (int k = 5; k >= 0; k--) begin
      if (v >= (23'(PROGRAM_WORDS) << k)) v = v - (23'(PROGRAM_WORDS) << k);
    end
    return v[PC_W-1:0];
  endfunction

  // item register
  logic [4:0]  op, rs, rt, rd;
  logic [31:0] imm;
  logic [9:0]  btgt, jtgt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_word[4:0];
      rs   <= in_word[9:5];
      rt   <= in_word[14:10];
      rd   <= in_word[19:15];
      imm  <= in_word[51:20];
      btgt <= in_word[61:52];
      jtgt <= in_word[71:62];
    end
  end

  // register file with per-entry written bits over the preset values
  logic [31:0] rf_mem [32];
  logic [31:0] rf_written;
  logic [31:0] a_raw, b_raw;
  logic        a_wr, b_wr;
  logic [31:0] a, b;

  always_ff @(posedge clk) begin
    a_raw <= rf_mem[rs];
    b_raw <= rf_mem[rt];
    a_wr  <= rf_written[rs];
    b_wr  <= rf_written[rt];
  end

  assign a = (rs == REG_ZERO) ? '0 : (a_wr ? a_raw : reg_preset(rs));
  assign b = (rt == REG_ZERO) ? '0 : (b_wr ? b_raw : reg_preset(rt));

  // architectural state
  logic [PC_W-1:0] pc;
  logic            halt_flag;
  logic [CNT_W-1:0] fill, idx;
  logic            found;

  // execute
  logic        halt_now;
  logic [31:0] alu, shamt_v;
  logic        sh_pass, sh_zero;

  assign halt_now = halt_flag ||
                    (op == OP_SLL && rs == REG_ZERO && rt == REG_ZERO && imm == '0);
  assign sh_pass  = imm[31] || imm == '0;
  assign sh_zero  = !imm[31] && imm >= 32'd32;
  assign shamt_v  = 32'(imm[4:0]);

  always_comb begin
    case (op)
      OP_ADD, OP_ADDU:   alu = a + b;
      OP_SUB, OP_SUBU:   alu = a - b;
      OP_AND:            alu = a & b;
      OP_OR:             alu = a | b;
      OP_NOR:            alu = ~(a | b);
      OP_SLT:            alu = 32'($signed(a) < $signed(b));
      OP_SLTU:           alu = 32'(a < b);
      OP_ADDI, OP_ADDIU: alu = a + imm;
      OP_ANDI:           alu = a & imm;
      OP_ORI:            alu = a | imm;
      OP_SLTI:           alu = 32'($signed(a) < $signed(imm));
      OP_SLTIU:          alu = 32'(a < imm);
      OP_SLL:            alu = sh_pass ? a : (sh_zero ? '0 : a << shamt_v);
      OP_SRL:            alu = sh_pass ? a : (sh_zero ? '0 : a >> shamt_v);
      OP_LW, OP_SW:      alu = a + imm;
      OP_BEQ, OP_BNE:    alu = a - b;
      default:           alu = '0;
    endcase
  end

  logic [31:0] alu_q, b_q;
  logic        halt_q;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      alu_q  <= alu;
      b_q    <= b;
      halt_q <= halt_now;
    end
  end

  // data store: fill-ordered entries searched one at a time through the look and compare states
  logic [31:0] key_mem  [DATA_ENTRIES];
  logic [31:0] word_mem [DATA_ENTRIES];
  logic [31:0] key_rd, word_rd;

  always_ff @(posedge clk) begin
    key_rd  <= key_mem[idx[IDX_W-1:0]];
    word_rd <= word_mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.srch_init) begin
      idx   <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.srch_next) idx <= idx + 1'b1;
      if (cmd.mark_hit) found <= 1'b1;
    end
  end

  assign sts.is_mem   = !halt_now && (op == OP_LW || op == OP_SW);
  assign sts.at_end   = idx == fill;
  assign sts.hit      = key_rd == alu_q;
  assign sts.out_free = !out_valid || out_ready;

  // commit
  logic            room, is_lw, is_sw, alloc, oom;
  logic            we, taken;
  logic [4:0]      wreg;
  logic [31:0]     wval, ld;
  logic [PC_W-1:0] pc_inc, pc_new;

  assign is_lw  = op == OP_LW;
  assign is_sw  = op == OP_SW;
  assign room   = fill < CNT_W'(DATA_ENTRIES);
  assign alloc  = (is_lw || is_sw) && !found && room;
  assign oom    = (is_lw || is_sw) && !found && !room;
  assign pc_inc = (32'(pc) + 32'd1 == 32'(PROGRAM_WORDS)) ? '0 : pc + 1'b1;

  always_comb begin
    we     = 1'b0;
    wreg   = REG_ZERO;
    wval   = '0;
    ld     = '0;
    taken  = 1'b0;
    pc_new = pc_inc;
    if (op <= OP_SLTU) begin
      we = 1'b1; wreg = rd; wval = alu_q;
    end else if (op <= OP_SRL) begin
      we = 1'b1; wreg = rt; wval = alu_q;
    end else if (is_lw) begin
      ld = found ? word_rd : '0;
      we = 1'b1; wreg = rt; wval = ld;
    end else if (op == OP_BEQ) begin
      taken = alu_q == '0;
    end else if (op == OP_BNE) begin
      taken = alu_q != '0;
    end else if (op == OP_J) begin
      pc_new = wrap_tgt(jtgt);
    end else if (op == OP_JAL) begin
      we = 1'b1; wreg = REG_RA; wval = 32'(pc_inc);
      pc_new = wrap_tgt(jtgt);
    end
    if (taken) pc_new = wrap_tgt(btgt);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !halt_q) begin
      if (we && wreg != REG_ZERO) rf_mem[wreg] <= wval;
      if (alloc) key_mem[idx[IDX_W-1:0]] <= alu_q;
      if (alloc && is_lw) word_mem[idx[IDX_W-1:0]] <= '0;
      if (is_sw && (found || room)) word_mem[idx[IDX_W-1:0]] <= b_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_written <= '0;
      pc         <= '0;
      halt_flag  <= 1'b0;
      fill       <= '0;
    end else if (cmd.commit) begin
      if (halt_q) begin
        halt_flag <= 1'b1;
      end else begin
        pc <= pc_new;
        if (alloc) fill <= fill + 1'b1;
        if (we && wreg != REG_ZERO) rf_written[wreg] <= 1'b1;
      end
    end
  end

  // result register
  logic [16:0]  pc_ext, pc_new_ext;
  logic [119:0] res_word;
  assign pc_ext     = 17'(pc);
  assign pc_new_ext = 17'(pc_new);

  always_comb begin
    res_word = '0;
    if (halt_q) begin
      res_word[9:0] = pc_ext[9:0];
      res_word[114] = 1'b1;
    end else begin
      res_word[9:0]    = pc_new_ext[9:0];
      res_word[41:10]  = alu_q;
      res_word[42]     = op <= OP_JAL && alu_q == '0;
      res_word[43]     = we;
      res_word[48:44]  = wreg;
      res_word[80:49]  = wval;
      res_word[112:81] = ld;
      res_word[113]    = taken;
      res_word[115]    = oom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.commit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_word <= res_word;
  end

endmodule

### rtl/core/mips_single_cycle_datapath.sv
// top level of the decoded-instruction datapath
// Executes one decoded MIPS-style instruction per input word and returns one
// result word. A plain instruction passes through the read, execute and commit
// states after acceptance, and a new word is accepted only once the last one
// has committed. The data store is a fill-ordered memory searched one entry per
// compare. lw/sw add a look and a compare state for each entry compared, up to
// and including the matching one. They add one more look state when the
// address is new and all entries in use were compared. The register file
// starts with gp and sp preset, and register 0 reads zero. sll $zero,$zero,0
// halts: from then on every word returns the frozen counter with halted set. A
// finished result sits in the output register while the next word is accepted.
module mips_single_cycle_datapath #(
  parameter int DATA_ENTRIES  = mscd_pkg::DEF_DATA_ENTRIES,
  parameter int PROGRAM_WORDS = mscd_pkg::DEF_PROGRAM_WORDS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation, src_reg_a, src_reg_b, dest_reg, immediate, branch_target, jump_target
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_pc, alu_result, zero_flag, write_enable, write_register, write_value,
  // load_data, branch_taken, halted, out_of_memory, zero pad
  output logic [119:0] m_tdata
);
  import mscd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mscd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mscd_dp #(
    .DATA_ENTRIES  (DATA_ENTRIES),
    .PROGRAM_WORDS (PROGRAM_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata)
  );

endmodule
